[rtl/core/prj_pkg.sv]
// Package of the range image projector: image geometry, command and register codes,
// shared structs and the square root and CORDIC step functions.
// No dependencies.
package prj_pkg;

	localparam int IMAGE_WIDTH  = 1024;
	localparam int IMAGE_HEIGHT = 64;
	localparam int COL_W        = $clog2(IMAGE_WIDTH);
	localparam int ROW_W        = $clog2(IMAGE_HEIGHT);
	localparam int QUO_W        = $clog2(IMAGE_HEIGHT + 1);
	localparam int NUM_W        = 17 + QUO_W;

	localparam int STORE_AW     = 16;
	localparam int STORE_DEPTH  = 1 << STORE_AW;
	localparam int RANGE_W      = 20;
	localparam int VWORD_W      = 32;
	localparam int VBIT_W       = $clog2(VWORD_W);
	localparam int VADDR_W      = STORE_AW - VBIT_W;
	localparam int VDEPTH       = STORE_DEPTH / VWORD_W;

	localparam int SQRT_STEPS   = 24;
	localparam int CORDIC_STEPS = 20;
	localparam int QUEUE_DEPTH  = 2;

	localparam logic [RANGE_W-1:0] RANGE_MAX = '1;

	localparam logic [1:0] CMD_CLEAR  = 2'd0;
	localparam logic [1:0] CMD_INSERT = 2'd1;
	localparam logic [1:0] CMD_LOOKUP = 2'd2;
	localparam logic [1:0] CMD_READ   = 2'd3;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_RANGE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FOV_UP     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FOV_DOWN   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NEW_MARGIN = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_GONE_MARGIN = 3'd5;

	typedef struct packed {
		logic [19:0] range_lo;
		logic [19:0] range_hi;
		logic [15:0] fov_up;
		logic [15:0] pitch_lo;
		logic [15:0] new_margin;
		logic [15:0] gone_margin;
	} cfg_t;

	typedef struct packed {
		logic [1:0]          cmd;
		logic                in_view;
		logic [STORE_AW-1:0] idx;
		logic [RANGE_W-1:0]  rng;
	} job_t;

	typedef struct packed {
		logic [27:0] rem;
		logic [23:0] root;
	} sq_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [25:0] acc;
	} cordic_t;

	function automatic logic [21:0] atan_lut(input logic [4:0] i);
		logic [21:0] v;
		unique case (i)
			5'd0:    v = 22'd2097152;
			5'd1:    v = 22'd1238021;
			5'd2:    v = 22'd654136;
			5'd3:    v = 22'd332050;
			5'd4:    v = 22'd166669;
			5'd5:    v = 22'd83416;
			5'd6:    v = 22'd41718;
			5'd7:    v = 22'd20860;
			5'd8:    v = 22'd10430;
			5'd9:    v = 22'd5215;
			5'd10:   v = 22'd2608;
			5'd11:   v = 22'd1304;
			5'd12:   v = 22'd652;
			5'd13:   v = 22'd326;
			5'd14:   v = 22'd163;
			5'd15:   v = 22'd81;
			5'd16:   v = 22'd41;
			5'd17:   v = 22'd20;
			5'd18:   v = 22'd10;
			5'd19:   v = 22'd5;
			default: v = 22'd0;
		endcase
		return v;
	endfunction

	function automatic sq_t sqrt_step(input sq_t s, input logic [1:0] bits);
		sq_t n;
		logic [27:0] rs;
		logic [27:0] tr;
		rs = {s.rem[25:0], bits};
		tr = {2'b00, s.root, 2'b01};
		if (rs >= tr) begin
			n.rem  = rs - tr;
			n.root = {s.root[22:0], 1'b1};
		end else begin
			n.rem  = rs;
			n.root = {s.root[22:0], 1'b0};
		end
		return n;
	endfunction

	function automatic cordic_t cordic_pre(input logic signed [31:0] x,
		input logic signed [31:0] y);
		cordic_t c;
		if (x < 0) begin
			if (y >= 0) begin
				c.x   = y;
				c.y   = -x;
				c.acc = 26'sd4194304;
			end else begin
				c.x   = -y;
				c.y   = x;
				c.acc = -26'sd4194304;
			end
		end else begin
			c.x   = x;
			c.y   = y;
			c.acc = '0;
		end
		return c;
	endfunction

	function automatic cordic_t cordic_iter(input cordic_t c, input logic [4:0] i);
		cordic_t n;
		logic signed [31:0] dx;
		logic signed [31:0] dy;
		logic signed [25:0] t;
		dx = c.y >>> i;
		dy = c.x >>> i;
		t  = signed'({4'b0000, atan_lut(i)});
		if (c.y < 0) begin
			n.x   = c.x - dx;
			n.y   = c.y + dy;
			n.acc = c.acc - t;
		end else begin
			n.x   = c.x + dx;
			n.y   = c.y - dy;
			n.acc = c.acc + t;
		end
		return n;
	endfunction

	function automatic logic signed [17:0] cordic_angle(input logic signed [25:0] acc);
		logic signed [25:0] t;
		t = acc + 26'sd128;
		return t[25:8];
	endfunction

endpackage

[rtl/core/prj_point_if.sv]
// Input channel of the range image projector: one point or command per beat.
// No dependencies.
interface prj_point_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [19:0] x_mm;
	logic [19:0] y_mm;
	logic [19:0] z_mm;
	logic [15:0] pixel_addr;

	modport source (output valid, command, x_mm, y_mm, z_mm, pixel_addr, input ready);
	modport sink (input valid, command, x_mm, y_mm, z_mm, pixel_addr, output ready);
endinterface

[rtl/core/prj_result_if.sv]
// Result channel of the range image projector: one result per beat.
// No dependencies.
interface prj_result_if;
	logic        valid;
	logic        ready;
	logic        in_view;
	logic [15:0] pixel_index;
	logic [19:0] point_range_mm;
	logic [19:0] stored_range_mm;
	logic        stored_valid;
	logic        updated;
	logic        nearer_new_object;
	logic        seen_through;
	logic        within_new_margin;

	modport source (output valid, in_view, pixel_index, point_range_mm, stored_range_mm,
		stored_valid, updated, nearer_new_object, seen_through, within_new_margin,
		input ready);
	modport sink (input valid, in_view, pixel_index, point_range_mm, stored_range_mm,
		stored_valid, updated, nearer_new_object, seen_through, within_new_margin,
		output ready);
endinterface

[rtl/core/prj_cfg_if.sv]
// Configuration write channel of the range image projector: register index and data.
// Depends on prj_pkg for the field widths.
interface prj_cfg_if;
	import prj_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/prj_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module prj_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

[rtl/core/prj_queue.sv]
// Short job queue between the projection front and the image back.
// Depends on prj_pkg.
module prj_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  prj_pkg::job_t push_job,
	output logic          pop_valid,
	input  logic          pop_ready,
	output prj_pkg::job_t pop_job
);
	import prj_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	job_t             slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_job    = slot_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push_job;
		end
	end
endmodule

[rtl/core/prj_front.sv]
// Projection front: accepts items, computes range, yaw and pitch, applies the
// range window and field of view, and queues a job with the pixel index.
// Depends on prj_pkg and prj_point_if.
module prj_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          enable,
	input  prj_pkg::cfg_t cfg,
	prj_point_if.sink     pt,
	output logic          push_valid,
	input  logic          push_ready,
	output prj_pkg::job_t push_job
);
	import prj_pkg::*;

	localparam logic [3:0] F_IDLE  = 4'd0;
	localparam logic [3:0] F_MUL   = 4'd1;
	localparam logic [3:0] F_SUM   = 4'd2;
	localparam logic [3:0] F_SQRT  = 4'd3;
	localparam logic [3:0] F_CINIT = 4'd4;
	localparam logic [3:0] F_CORD  = 4'd5;
	localparam logic [3:0] F_CHECK = 4'd6;
	localparam logic [3:0] F_DIV   = 4'd7;
	localparam logic [3:0] F_IDX   = 4'd8;
	localparam logic [3:0] F_PUSH  = 4'd9;

	logic [3:0]         st_q;
	logic [4:0]         cnt_q;
	logic               take;

	logic [1:0]         cmd_q;
	logic signed [19:0] x_q;
	logic signed [19:0] y_q;
	logic signed [19:0] z_q;
	logic [39:0]        x2_q;
	logic [39:0]        y2_q;
	logic [39:0]        z2_q;
	logic [39:0]        lo_q;
	logic [39:0]        hi_q;
	logic               win_q;
	logic [47:0]        na_q;
	logic [47:0]        nb_q;
	sq_t                sa_q;
	sq_t                sb_q;
	cordic_t            cy_q;
	cordic_t            cp_q;
	logic               yzero_q;
	logic               pzero_q;
	logic [COL_W-1:0]   col_q;
	logic [NUM_W-1:0]   num_q;
	logic [NUM_W-1:0]   dsh_q;
	logic [QUO_W-1:0]   quo_q;
	job_t               job_q;

	logic signed [39:0] xx;
	logic signed [39:0] yy;
	logic signed [39:0] zz;
	logic [39:0]        s_w;
	logic [39:0]        hs_w;
	logic signed [17:0] yaw;
	logic signed [17:0] pitch;
	logic signed [17:0] up_w;
	logic signed [17:0] dn_w;
	logic signed [17:0] diff;
	logic signed [17:0] den;
	logic               pass;
	logic signed [18:0] u_w;
	logic [17:0]        uc;
	logic [31:0]        cprod;
	logic [15:0]        craw;
	logic [COL_W-1:0]   col_w;
	logic [RANGE_W-1:0] rng_w;
	logic [ROW_W-1:0]   row_w;
	logic [31:0]        idx_w;

	assign pt.ready   = (st_q == F_IDLE) && enable;
	assign take       = pt.valid && pt.ready;
	assign push_valid = (st_q == F_PUSH);
	assign push_job   = job_q;

	always_comb begin
		xx    = x_q * x_q;
		yy    = y_q * y_q;
		zz    = z_q * z_q;
		hs_w  = x2_q + y2_q;
		s_w   = hs_w + z2_q;
		rng_w = (sa_q.root > 24'(RANGE_MAX)) ? RANGE_MAX : sa_q.root[RANGE_W-1:0];
		yaw   = yzero_q ? '0 : cordic_angle(cy_q.acc);
		pitch = pzero_q ? '0 : cordic_angle(cp_q.acc);
		up_w  = {{2{cfg.fov_up[15]}}, cfg.fov_up};
		dn_w  = {{2{cfg.pitch_lo[15]}}, cfg.pitch_lo};
		pass  = (pitch <= up_w) && (pitch >= dn_w);
		diff  = up_w - pitch;
		den   = up_w - dn_w;
		u_w   = {yaw[17], yaw} + 19'sd32768;
		uc    = u_w[18] ? '0 : u_w[17:0];
		cprod = 32'(uc) * 32'(IMAGE_WIDTH);
		craw  = cprod[31:16];
		col_w = (craw > 16'(IMAGE_WIDTH - 1)) ? COL_W'(IMAGE_WIDTH - 1) : craw[COL_W-1:0];
		row_w = (quo_q > QUO_W'(IMAGE_HEIGHT - 1)) ? ROW_W'(IMAGE_HEIGHT - 1)
			: quo_q[ROW_W-1:0];
		idx_w = 32'(row_w) * 32'(IMAGE_WIDTH) + 32'(col_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= F_IDLE;
			cnt_q <= '0;
		end else begin
			unique case (st_q)
				F_IDLE: begin
					if (take) begin
						st_q <= (pt.command == CMD_INSERT || pt.command == CMD_LOOKUP)
							? F_MUL : F_PUSH;
					end
				end
				F_MUL: st_q <= F_SUM;
				F_SUM: begin
					st_q  <= F_SQRT;
					cnt_q <= '0;
				end
				F_SQRT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 5'(SQRT_STEPS - 1)) begin
						st_q <= F_CINIT;
					end
				end
				F_CINIT: begin
					cnt_q <= '0;
					st_q  <= win_q ? F_CORD : F_PUSH;
				end
				F_CORD: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 5'(CORDIC_STEPS - 1)) begin
						st_q <= F_CHECK;
					end
				end
				F_CHECK: begin
					cnt_q <= '0;
					if (!pass) begin
						st_q <= F_PUSH;
					end else if (den == '0) begin
						st_q <= F_IDX;
					end else begin
						st_q <= F_DIV;
					end
				end
				F_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 5'(QUO_W - 1)) begin
						st_q <= F_IDX;
					end
				end
				F_IDX: st_q <= F_PUSH;
				F_PUSH: begin
					if (push_ready) begin
						st_q <= F_IDLE;
					end
				end
				default: st_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			F_IDLE: begin
				if (take) begin
					cmd_q         <= pt.command;
					x_q           <= pt.x_mm;
					y_q           <= pt.y_mm;
					z_q           <= pt.z_mm;
					job_q.cmd     <= pt.command;
					job_q.in_view <= 1'b0;
					job_q.idx     <= (pt.command == CMD_READ) ? pt.pixel_addr : '0;
					job_q.rng     <= '0;
				end
			end
			F_MUL: begin
				x2_q <= xx;
				y2_q <= yy;
				z2_q <= zz;
				lo_q <= cfg.range_lo * cfg.range_lo;
				hi_q <= cfg.range_hi * cfg.range_hi;
			end
			F_SUM: begin
				win_q <= (s_w >= lo_q) && (s_w <= hi_q);
				na_q  <= {8'd0, s_w};
				nb_q  <= {hs_w, 8'd0};
				sa_q  <= '0;
				sb_q  <= '0;
			end
			F_SQRT: begin
				sa_q <= sqrt_step(sa_q, na_q[47:46]);
				sb_q <= sqrt_step(sb_q, nb_q[47:46]);
				na_q <= {na_q[45:0], 2'b00};
				nb_q <= {nb_q[45:0], 2'b00};
			end
			F_CINIT: begin
				job_q.cmd     <= cmd_q;
				job_q.in_view <= 1'b0;
				job_q.idx     <= '0;
				job_q.rng     <= rng_w;
				cy_q    <= cordic_pre({{4{x_q[19]}}, x_q, 8'd0}, {{4{y_q[19]}}, y_q, 8'd0});
				cp_q    <= cordic_pre({8'd0, sb_q.root}, {{8{z_q[19]}}, z_q, 4'd0});
				yzero_q <= (x_q == '0) && (y_q == '0);
				pzero_q <= (sb_q.root == '0) && (z_q == '0);
			end
			F_CORD: begin
				cy_q <= cordic_iter(cy_q, cnt_q);
				cp_q <= cordic_iter(cp_q, cnt_q);
			end
			F_CHECK: begin
				col_q <= col_w;
				num_q <= NUM_W'(diff[16:0]) * NUM_W'(IMAGE_HEIGHT);
				dsh_q <= NUM_W'(den[16:0]) << (QUO_W - 1);
				quo_q <= '0;
			end
			F_DIV: begin
				if (num_q >= dsh_q) begin
					num_q <= num_q - dsh_q;
					quo_q <= {quo_q[QUO_W-2:0], 1'b1};
				end else begin
					quo_q <= {quo_q[QUO_W-2:0], 1'b0};
				end
				dsh_q <= dsh_q >> 1;
			end
			F_IDX: begin
				job_q.in_view <= 1'b1;
				job_q.idx     <= idx_w[STORE_AW-1:0];
			end
			default: ;
		endcase
	end
endmodule

[rtl/core/prj_back.sv]
// Image back: keeps the nearest range per pixel in RAM with packed valid words,
// runs the clearing pass, evaluates margins and holds the result register.
// Depends on prj_pkg, prj_ram and prj_result_if.
module prj_back (
	input  logic          clk,
	input  logic          arst_n,
	input  prj_pkg::cfg_t cfg,
	input  logic          pop_valid,
	output logic          pop_ready,
	input  prj_pkg::job_t pop_job,
	output logic          init_done,
	prj_result_if.source  res
);
	import prj_pkg::*;

	localparam logic [2:0] B_INIT  = 3'd0;
	localparam logic [2:0] B_IDLE  = 3'd1;
	localparam logic [2:0] B_SWEEP = 3'd2;
	localparam logic [2:0] B_DONE  = 3'd3;
	localparam logic [2:0] B_EVAL  = 3'd4;

	logic [2:0]         st_q;
	logic [VADDR_W-1:0] sweep_q;
	logic               out_valid_q;
	job_t               job_q;

	logic               out_free;
	logic               load;
	logic               sweeping;
	logic               take;
	logic [STORE_AW-1:0] raddr;
	logic [VWORD_W-1:0] vword;
	logic [RANGE_W-1:0] rword;
	logic               vbit;
	logic               looked;
	logic               chk;
	logic [RANGE_W-1:0] st_rng;
	logic               upd;
	logic               nearer;
	logic               seen;
	logic               margin_ok;
	logic               v_we;
	logic [VADDR_W-1:0] v_waddr;
	logic [VWORD_W-1:0] v_wdata;

	assign sweeping  = (st_q == B_INIT) || (st_q == B_SWEEP);
	assign init_done = (st_q != B_INIT);
	assign pop_ready = (st_q == B_IDLE);
	assign take      = pop_valid && pop_ready;
	assign out_free  = !out_valid_q || res.ready;
	assign load      = out_free && ((st_q == B_EVAL) || (st_q == B_DONE));
	assign raddr     = (st_q == B_IDLE) ? pop_job.idx : job_q.idx;

	always_comb begin
		vbit      = vword[job_q.idx[VBIT_W-1:0]];
		looked    = (job_q.cmd == CMD_READ) || job_q.in_view;
		chk       = job_q.in_view && vbit;
		st_rng    = (looked && vbit) ? rword : '0;
		nearer    = chk && ((21'(job_q.rng) + 21'(cfg.new_margin)) < 21'(rword));
		seen      = chk && ((21'(job_q.rng) + 21'(cfg.gone_margin)) < 21'(rword));
		margin_ok = chk && ((21'(rword) + 21'(cfg.new_margin)) >= 21'(job_q.rng));
		upd       = (job_q.cmd == CMD_INSERT) && job_q.in_view && (!vbit || job_q.rng < rword);
		v_we      = sweeping || (load && (st_q == B_EVAL) && upd);
		v_waddr   = sweeping ? sweep_q : job_q.idx[STORE_AW-1:VBIT_W];
		v_wdata   = sweeping ? '0 : (vword | (VWORD_W'(1) << job_q.idx[VBIT_W-1:0]));
	end

	prj_ram #(
		.WIDTH (VWORD_W),
		.DEPTH (VDEPTH)
	) u_valid_ram (
		.clk   (clk),
		.we    (v_we),
		.waddr (v_waddr),
		.wdata (v_wdata),
		.raddr (raddr[STORE_AW-1:VBIT_W]),
		.rdata (vword)
	);

	prj_ram #(
		.WIDTH (RANGE_W),
		.DEPTH (STORE_DEPTH)
	) u_range_ram (
		.clk   (clk),
		.we    (load && (st_q == B_EVAL) && upd),
		.waddr (job_q.idx),
		.wdata (job_q.rng),
		.raddr (raddr),
		.rdata (rword)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= B_INIT;
			sweep_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				B_INIT, B_SWEEP: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == VADDR_W'(VDEPTH - 1)) begin
						st_q <= (st_q == B_INIT) ? B_IDLE : B_DONE;
					end
				end
				B_IDLE: begin
					if (take) begin
						sweep_q <= '0;
						st_q    <= (pop_job.cmd == CMD_CLEAR) ? B_SWEEP : B_EVAL;
					end
				end
				B_DONE, B_EVAL: begin
					if (load) begin
						st_q <= B_IDLE;
					end
				end
				default: st_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			job_q <= pop_job;
		end
		if (load) begin
			if (st_q == B_DONE) begin
				res.in_view           <= 1'b0;
				res.pixel_index       <= '0;
				res.point_range_mm    <= '0;
				res.stored_range_mm   <= '0;
				res.stored_valid      <= 1'b0;
				res.updated           <= 1'b0;
				res.nearer_new_object <= 1'b0;
				res.seen_through      <= 1'b0;
				res.within_new_margin <= 1'b0;
			end else begin
				res.in_view           <= job_q.in_view;
				res.pixel_index       <= job_q.idx;
				res.point_range_mm    <= job_q.rng;
				res.stored_range_mm   <= st_rng;
				res.stored_valid      <= looked && vbit;
				res.updated           <= upd;
				res.nearer_new_object <= nearer;
				res.seen_through      <= seen;
				res.within_new_margin <= margin_ok;
			end
		end
	end

	assign res.valid = out_valid_q;
endmodule

[rtl/core/range_image_projector_top.sv]
// Top level of the range image projector: configuration registers, projection
// front, job queue and image back.
// Depends on prj_pkg, the three channel interfaces, prj_front, prj_queue, prj_back.
//
// Channels: pt carries one command per beat (clear, insert, lookup, read pixel)
// with x_mm, y_mm, z_mm and pixel_addr; res returns exactly one result per beat;
// cfg writes one register per beat and is always ready.
// Insert and lookup pass through the front in order: square, sum, square root,
// setup, a CORDIC for yaw and pitch, check, a row divide of one quotient bit per
// cycle, the index step and the hand-off.
// Points outside the range window skip the CORDIC and the divide.
// Read pixel skips the projection and goes straight to the hand-off.
// The front takes no new point until it has handed off the last one. A clear
// sweeps all 2048 valid words.
// After reset the same sweep runs, and pt stays not ready until it ends.
// Configuration resets to its defaults.
// When res stalls, the result holds in its register, the back waits, and the
// front keeps accepting until the two-entry queue is full.
module range_image_projector_top (
	input  logic         clk,
	input  logic         arst_n,
	prj_point_if.sink    pt,
	prj_result_if.source res,
	prj_cfg_if.sink      cfg
);
	import prj_pkg::*;

	cfg_t cfg_q;
	logic push_valid;
	logic push_ready;
	job_t push_job;
	logic pop_valid;
	logic pop_ready;
	job_t pop_job;
	logic init_done;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.range_lo    <= 20'd1000;
			cfg_q.range_hi    <= 20'd100000;
			cfg_q.fov_up      <= 16'd2731;
			cfg_q.pitch_lo    <= 16'(-16'sd4551);
			cfg_q.new_margin  <= 16'd500;
			cfg_q.gone_margin <= 16'd500;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_MIN_RANGE:   cfg_q.range_lo    <= cfg.data;
				REG_MAX_RANGE:   cfg_q.range_hi    <= cfg.data;
				REG_FOV_UP:      cfg_q.fov_up      <= cfg.data[15:0];
				REG_FOV_DOWN:    cfg_q.pitch_lo    <= cfg.data[15:0];
				REG_NEW_MARGIN:  cfg_q.new_margin  <= cfg.data[15:0];
				REG_GONE_MARGIN: cfg_q.gone_margin <= cfg.data[15:0];
				default: ;
			endcase
		end
	end

	prj_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.enable     (init_done),
		.cfg        (cfg_q),
		.pt         (pt),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job)
	);

	prj_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_job    (pop_job)
	);

	prj_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_job   (pop_job),
		.init_done (init_done),
		.res       (res)
	);
endmodule

[bench/range_image_projector_top_tb.sv]
// Self-checking bench of range_image_projector_top: a clocked driver and monitor with
// random idling on both channels, a bit-exact projector predictor and a result queue.
// Depends on prj_pkg and the point, result and configuration channel interfaces.
`timescale 1ns / 100ps

module range_image_projector_top_tb;
	import prj_pkg::*;

	localparam int CYCLE_LIMIT = 4000000;
	localparam int SETTLE_CYCLES = 2200;

	typedef struct packed {
		logic [1:0]         cmd;
		logic signed [19:0] x;
		logic signed [19:0] y;
		logic signed [19:0] z;
		logic [15:0]        addr;
	} point_t;

	typedef struct packed {
		logic        in_view;
		logic [15:0] pixel_index;
		logic [19:0] point_range;
		logic [19:0] stored_range;
		logic        stored_valid;
		logic        updated;
		logic        nearer_new_object;
		logic        seen_through;
		logic        within_new_margin;
	} verdict_t;

	logic clk;
	logic arst_n;

	prj_point_if  pt_if();
	prj_result_if res_if();
	prj_cfg_if    cfg_if();

	range_image_projector_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pt     (pt_if),
		.res    (res_if),
		.cfg    (cfg_if)
	);

	point_t   pending_q[$];
	verdict_t verdict_q[$];
	point_t   held_point;
	int       recent_pix[$];
	int       idle_send;
	int       idle_recv;
	int       mismatches;
	int       cycles;

	// image and register copies
	logic [19:0] img_range [STORE_DEPTH];
	bit          img_valid [STORE_DEPTH];
	logic [19:0] min_rng, max_rng;
	logic signed [15:0] fov_up, fov_dn;
	logic [15:0] new_mg, gone_mg;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic longint unsigned root_floor(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint bam_atan2(longint vx, longint vy);
		longint acc, t, dx, dy;
		longint tab [20] = '{2097152, 1238021, 654136, 332050, 166669, 83416, 41718,
			20860, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5};
		acc = 0;
		if (vx == 0 && vy == 0) return 0;
		if (vx < 0) begin
			t = vx;
			if (vy >= 0) begin
				vx = vy;
				vy = -t;
				acc = 64'sd1 << 22;
			end else begin
				vx = -vy;
				vy = t;
				acc = -(64'sd1 << 22);
			end
		end
		for (int i = 0; i < 20; i++) begin
			dx = vy >>> i;
			dy = vx >>> i;
			if (vy < 0) begin
				vx = vx - dx;
				vy = vy + dy;
				acc = acc - tab[i];
			end else begin
				vx = vx + dx;
				vy = vy - dy;
				acc = acc + tab[i];
			end
		end
		return (acc + 128) >>> 8;
	endfunction

	function automatic bit project_point(longint x, longint y, longint z,
		output int idx, output logic [19:0] rng);
		longint unsigned hs, s, r, lo, hi;
		longint up, dn, pitch, yaw, u, v, den;
		hs = x * x + y * y;
		s = hs + z * z;
		r = root_floor(s);
		rng = (r > 64'd1048575) ? 20'hFFFFF : r[19:0];
		idx = 0;
		lo = longint'(min_rng) * longint'(min_rng);
		hi = longint'(max_rng) * longint'(max_rng);
		if (s < lo || s > hi) return 1'b0;
		pitch = bam_atan2(longint'(root_floor(hs << 8)), z * 16);
		yaw = bam_atan2(x * 256, y * 256);
		up = fov_up;
		dn = fov_dn;
		if (pitch > up || pitch < dn) return 1'b0;
		u = yaw + 32768;
		if (u < 0) u = 0;
		u = (u * IMAGE_WIDTH) >>> 16;
		if (u > IMAGE_WIDTH - 1) u = IMAGE_WIDTH - 1;
		den = up - dn;
		v = (den > 0) ? ((up - pitch) * IMAGE_HEIGHT) / den : 0;
		if (v < 0) v = 0;
		if (v > IMAGE_HEIGHT - 1) v = IMAGE_HEIGHT - 1;
		idx = int'((v * IMAGE_WIDTH + u) & 64'hFFFF);
		return 1'b1;
	endfunction

	function automatic verdict_t predict_verdict(point_t p);
		verdict_t e;
		int idx;
		logic [19:0] rng;
		longint st;
		e = '0;
		if (p.cmd == CMD_CLEAR) begin
			foreach (img_valid[i]) img_valid[i] = 1'b0;
		end else if (p.cmd == CMD_READ) begin
			e.pixel_index = p.addr;
			if (img_valid[p.addr]) begin
				e.stored_range = img_range[p.addr];
				e.stored_valid = 1'b1;
			end
		end else begin
			e.in_view = project_point(p.x, p.y, p.z, idx, rng);
			e.point_range = rng;
			if (e.in_view) begin
				e.pixel_index = idx[15:0];
				recent_pix.insert(recent_pix.size(), idx);
				if (recent_pix.size() > 32) void'(recent_pix.pop_front());
				if (img_valid[idx]) begin
					st = img_range[idx];
					e.stored_range = img_range[idx];
					e.stored_valid = 1'b1;
					e.nearer_new_object = (longint'(rng) + new_mg < st);
					e.seen_through = (longint'(rng) + gone_mg < st);
					e.within_new_margin = (st + new_mg >= longint'(rng));
				end
				if (p.cmd == CMD_INSERT && (!img_valid[idx] || rng < img_range[idx])) begin
					img_range[idx] = rng;
					img_valid[idx] = 1'b1;
					e.updated = 1'b1;
				end
			end
		end
		return e;
	endfunction

	function automatic logic signed [19:0] clip20(real v);
		if (v > 524287.0) return 20'sd524287;
		if (v < -524288.0) return -20'sd524288;
		return 20'($rtoi(v));
	endfunction

	// mostly points inside the window and field of view, reads mostly of recent pixels
	function automatic point_t make_point();
		point_t p;
		real rr, yw, pa, pi;
		int sel, lo_b, hi_b;
		pi = 3.14159265358979323846;
		p = '0;
		sel = $urandom_range(99);
		if (sel < 2) p.cmd = CMD_CLEAR;
		else if (sel < 48) p.cmd = CMD_INSERT;
		else if (sel < 82) p.cmd = CMD_LOOKUP;
		else p.cmd = CMD_READ;
		if (p.cmd == CMD_READ) begin
			if (recent_pix.size() > 0 && $urandom_range(3) != 0)
				p.addr = 16'(recent_pix[$urandom_range(recent_pix.size() - 1)]);
			else
				p.addr = 16'($urandom);
			return p;
		end
		p.addr = 16'($urandom);
		sel = $urandom_range(99);
		if (sel < 15) begin
			p.x = 20'($urandom);
			p.y = 20'($urandom);
			p.z = 20'($urandom);
		end else begin
			rr = real'($urandom_range(200, 1 << $urandom_range(10, 19)));
			if (sel < 45) rr = real'($urandom_range(900, 3000));
			yw = (real'($urandom_range(65535)) / 65536.0 - 0.5) * 2.0 * pi;
			lo_b = fov_dn;
			hi_b = fov_up;
			if (hi_b > lo_b) pa = real'(int'($urandom_range(hi_b - lo_b)) + lo_b);
			else pa = real'(hi_b);
			if (sel < 52) pa = 0.0;
			pa = pa * 2.0 * pi / 65536.0;
			p.x = clip20(rr * $cos(pa) * $cos(yw));
			p.y = clip20(rr * $cos(pa) * $sin(yw));
			p.z = clip20(rr * $sin(pa));
			if (sel < 52) p.z = '0;
		end
		return p;
	endfunction

	function automatic point_t pt_of(logic [1:0] c, int x, int y, int z, int a);
		point_t p;
		p.cmd = c;
		p.x = 20'(x);
		p.y = 20'(y);
		p.z = 20'(z);
		p.addr = 16'(a);
		return p;
	endfunction

	function automatic void add_pending(point_t p);
		pending_q.insert(pending_q.size(), p);
	endfunction

	// point driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pt_if.valid <= 1'b0;
		end else begin
			if (pt_if.valid && pt_if.ready)
				verdict_q.insert(verdict_q.size(), predict_verdict(held_point));
			if (!pt_if.valid || pt_if.ready) begin
				if (pending_q.size() > 0 && $urandom_range(99) >= idle_send) begin
					held_point = pending_q.pop_front();
					pt_if.valid      <= 1'b1;
					pt_if.command    <= held_point.cmd;
					pt_if.x_mm       <= held_point.x;
					pt_if.y_mm       <= held_point.y;
					pt_if.z_mm       <= held_point.z;
					pt_if.pixel_addr <= held_point.addr;
				end else begin
					pt_if.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		verdict_t got, want;
		if (!arst_n) begin
			res_if.ready <= 1'b0;
		end else begin
			if (res_if.valid && res_if.ready) begin
				got.in_view           = res_if.in_view;
				got.pixel_index       = res_if.pixel_index;
				got.point_range       = res_if.point_range_mm;
				got.stored_range      = res_if.stored_range_mm;
				got.stored_valid      = res_if.stored_valid;
				got.updated           = res_if.updated;
				got.nearer_new_object = res_if.nearer_new_object;
				got.seen_through      = res_if.seen_through;
				got.within_new_margin = res_if.within_new_margin;
				if (verdict_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected result beat: %p", got);
				end else begin
					want = verdict_q.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("result mismatch:\n  expected %p\n  actual   %p", want, got);
					end
				end
			end
			res_if.ready <= ($urandom_range(99) >= idle_recv);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= val[19:0];
		do @(posedge clk); while (!cfg_if.ready);
		case (idx)
			REG_MIN_RANGE:   min_rng = val[19:0];
			REG_MAX_RANGE:   max_rng = val[19:0];
			REG_FOV_UP:      fov_up = val[15:0];
			REG_FOV_DOWN:    fov_dn = val[15:0];
			REG_NEW_MARGIN:  new_mg = val[15:0];
			REG_GONE_MARGIN: gone_mg = val[15:0];
			default: ;
		endcase
	endtask

	task automatic setup_regs(int mn, int mx, int up, int dn, int nm, int gm);
		@(negedge clk);
		write_reg(REG_MIN_RANGE, mn);
		write_reg(REG_MAX_RANGE, mx);
		write_reg(REG_FOV_UP, up);
		write_reg(REG_FOV_DOWN, dn);
		write_reg(REG_NEW_MARGIN, nm);
		write_reg(REG_GONE_MARGIN, gm);
		cfg_if.valid <= 1'b0;
	endtask

	task automatic drain();
		do @(negedge clk); while (pending_q.size() > 0 || pt_if.valid || verdict_q.size() > 0);
	endtask

	initial begin
		arst_n = 1'b0;
		pt_if.valid = 1'b0;
		pt_if.command = CMD_CLEAR;
		pt_if.x_mm = '0;
		pt_if.y_mm = '0;
		pt_if.z_mm = '0;
		pt_if.pixel_addr = '0;
		res_if.ready = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.index = '0;
		cfg_if.data = '0;
		mismatches = 0;
		cycles = 0;
		idle_send = 29;
		idle_recv = 63;
		foreach (img_valid[i]) img_valid[i] = 1'b0;
		foreach (img_range[i]) img_range[i] = '0;
		min_rng = 20'd1000;
		max_rng = 20'd100000;
		fov_up = 16'sd2731;
		fov_dn = -16'sd4551;
		new_mg = 16'd500;
		gone_mg = 16'd500;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		add_pending(pt_of(CMD_CLEAR, 0, 0, 0, 0));
		add_pending(pt_of(CMD_INSERT, 0, 0, 0, 0));
		add_pending(pt_of(CMD_INSERT, 999, 0, 0, 0));
		add_pending(pt_of(CMD_INSERT, 1000, 0, 0, 0));
		add_pending(pt_of(CMD_INSERT, 100000, 0, 0, 0));
		add_pending(pt_of(CMD_INSERT, 100001, 0, 0, 0));
		add_pending(pt_of(CMD_INSERT, 20000, 0, 0, 0));
		add_pending(pt_of(CMD_INSERT, 20000, 0, 0, 0));
		add_pending(pt_of(CMD_INSERT, 21000, 0, 0, 0));
		add_pending(pt_of(CMD_LOOKUP, 19200, 0, 0, 0));
		add_pending(pt_of(CMD_LOOKUP, 19600, 0, 0, 0));
		add_pending(pt_of(CMD_LOOKUP, 30000, 0, 0, 0));
		add_pending(pt_of(CMD_INSERT, 10000, 0, 0, 0));
		add_pending(pt_of(CMD_READ, 0, 0, 0, 32 * 1024 + 512));
		add_pending(pt_of(CMD_READ, 0, 0, 0, 65535));
		add_pending(pt_of(CMD_READ, 0, 0, 0, 0));
		add_pending(pt_of(CMD_INSERT, -524288, -524288, -524288, 65535));
		add_pending(pt_of(CMD_INSERT, 524287, 524287, 524287, 0));
		add_pending(pt_of(CMD_INSERT, -30000, 1, 0, 0));
		add_pending(pt_of(CMD_INSERT, -30000, -1, 0, 0));
		add_pending(pt_of(CMD_LOOKUP, 0, 5000, 800, 0));
		add_pending(pt_of(CMD_LOOKUP, 0, -5000, -2000, 0));
		add_pending(pt_of(CMD_LOOKUP, 5000, 0, 5000, 0));
		add_pending(pt_of(CMD_CLEAR, 0, 0, 0, 0));
		add_pending(pt_of(CMD_READ, 0, 0, 0, 32 * 1024 + 512));

		for (int ph = 0; ph < 6; ph++) begin
			drain();
			repeat (SETTLE_CYCLES) @(negedge clk);
			idle_send = (ph < 2) ? 29 : (ph < 4) ? 63 : 0;
			idle_recv = (ph < 2) ? 63 : (ph < 4) ? 29 : 0;
			case (ph)
				1: setup_regs(0, 1048575, 16384, -16384, 0, 65535);
				2: setup_regs(5000, 20000, 0, 0, 65535, 0);
				3: setup_regs(1048575, 0, -100, 100, 200, 300);
				4: setup_regs(100, 60000, 1000, -1000, 50, 2000);
				5: setup_regs(1000, 100000, 2731, -4551, 500, 500);
				default: ;
			endcase
			for (int n = 0; n < 170; n++) begin
				add_pending(make_point());
				if (n == 85) drain();
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatches == 0 && verdict_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
